// File: hw/rtl/jse_pkg.sv
`default_nettype none
package jse_pkg;

	localparam int STEP_W = 4;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;

	localparam logic [7:0] BYTE_BS  = 8'h08;
	localparam logic [7:0] BYTE_TAB = 8'h09;
	localparam logic [7:0] BYTE_LF  = 8'h0A;
	localparam logic [7:0] BYTE_FF  = 8'h0C;
	localparam logic [7:0] BYTE_CR  = 8'h0D;
	localparam logic [7:0] CTRL_LIMIT = 8'h20;

	localparam logic [20:0] SUPP_BASE = 21'h10000;
	localparam logic [15:0] SURR_HI   = 16'hD800;
	localparam logic [15:0] SURR_LO   = 16'hDC00;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_string;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       run_last;
	} out_word_t;

	typedef enum logic [2:0] {
		TAIL_NONE,
		TAIL_CHAR,
		TAIL_SHORT,
		TAIL_U1,
		TAIL_U2
	} tail_kind_t;

	// One input byte's worth of output: held raw bytes first, then the tail.
	typedef struct packed {
		logic [1:0]      raw_cnt;
		logic [2:0][7:0] raw_bytes;
		tail_kind_t      kind;
		logic [7:0]      chr;
		logic [15:0]     hi;
		logic [15:0]     lo;
	} job_t;

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) begin
			return 8'h30 + {4'h0, n};
		end
		return 8'h57 + {4'h0, n};
	endfunction

	function automatic logic [STEP_W-1:0] tail_len(input tail_kind_t k);
		case (k)
			TAIL_CHAR:  return STEP_W'(1);
			TAIL_SHORT: return STEP_W'(2);
			TAIL_U1:    return STEP_W'(6);
			TAIL_U2:    return STEP_W'(12);
			default:    return STEP_W'(0);
		endcase
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/jse_front.sv
`default_nettype none
module jse_front
	import jse_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cfg_we,
	input  wire logic     cfg_data,
	input  wire in_word_t item,
	input  wire logic     accept,
	output logic          job_push,
	output job_t          job
);

	logic        esc_q;
	logic [1:0]  pend_q;
	logic [1:0]  hcnt_q;
	logic [20:0] acc_q;
	logic [7:0]  held_q [3];

	logic [1:0]  pend_n;
	logic [1:0]  hcnt_n;
	logic [20:0] acc_n;
	logic        held_we;
	logic [1:0]  held_idx;

	logic [7:0]  b;
	logic        eos;
	logic        is_open;
	logic        is_cont;
	logic [1:0]  lead_len;
	logic [20:0] lead_acc;
	logic [20:0] acc_cont;
	logic [20:0] supp;

	assign b   = item.in_byte;
	assign eos = item.end_of_string;
	assign is_open = (pend_q != 2'd0);
	assign is_cont = (b[7:6] == 2'b10);
	assign acc_cont = {acc_q[14:0], b[5:0]};
	assign supp = acc_cont - SUPP_BASE;

	always_comb begin
		lead_len = 2'd0;
		lead_acc = '0;
		if (b[7:5] == 3'b110) begin
			lead_len = 2'd1;
			lead_acc = {16'h0, b[4:0]};
		end else if (b[7:4] == 4'b1110) begin
			lead_len = 2'd2;
			lead_acc = {17'h0, b[3:0]};
		end else if (b[7:3] == 5'b11110) begin
			lead_len = 2'd3;
			lead_acc = {18'h0, b[2:0]};
		end
	end

	always_comb begin
		job = '0;
		job.raw_bytes = {held_q[2], held_q[1], held_q[0]};
		job.kind = TAIL_NONE;
		pend_n = pend_q;
		hcnt_n = hcnt_q;
		acc_n = acc_q;
		held_we = 1'b0;
		held_idx = hcnt_q;
		if (is_open && is_cont) begin
			acc_n = acc_cont;
			if (hcnt_q != 2'd3) begin
				held_we = 1'b1;
				hcnt_n = hcnt_q + 2'd1;
			end
			pend_n = pend_q - 2'd1;
			if (pend_n == 2'd0 || eos) begin
				if (acc_cont[20:16] != 5'd0) begin
					job.kind = TAIL_U2;
					job.hi = SURR_HI + {6'h0, supp[19:10]};
					job.lo = SURR_LO + {6'h0, supp[9:0]};
				end else begin
					job.kind = TAIL_U1;
					job.hi = acc_cont[15:0];
				end
				pend_n = 2'd0;
				hcnt_n = 2'd0;
				acc_n = '0;
			end
		end else begin
			// A broken sequence flushes its held bytes before this byte is handled.
			job.raw_cnt = is_open ? hcnt_q : 2'd0;
			pend_n = 2'd0;
			hcnt_n = 2'd0;
			acc_n = '0;
			case (b)
				CH_QUOTE: begin
					job.kind = TAIL_SHORT;
					job.chr = CH_QUOTE;
				end
				CH_BSLASH: begin
					job.kind = TAIL_SHORT;
					job.chr = CH_BSLASH;
				end
				BYTE_BS: begin
					job.kind = TAIL_SHORT;
					job.chr = CH_B;
				end
				BYTE_FF: begin
					job.kind = TAIL_SHORT;
					job.chr = CH_F;
				end
				BYTE_LF: begin
					job.kind = TAIL_SHORT;
					job.chr = CH_N;
				end
				BYTE_CR: begin
					job.kind = TAIL_SHORT;
					job.chr = CH_R;
				end
				BYTE_TAB: begin
					job.kind = TAIL_SHORT;
					job.chr = CH_T;
				end
				default: begin
					if (b < CTRL_LIMIT) begin
						job.kind = TAIL_U1;
						job.hi = {8'h00, b};
					end else if (esc_q && b[7] && lead_len != 2'd0) begin
						held_we = 1'b1;
						held_idx = 2'd0;
						if (eos) begin
							// A lead byte that ends the string emits its partial codepoint.
							job.kind = TAIL_U1;
							job.hi = lead_acc[15:0];
						end else begin
							pend_n = lead_len;
							hcnt_n = 2'd1;
							acc_n = lead_acc;
						end
					end else begin
						job.kind = TAIL_CHAR;
						job.chr = b;
					end
				end
			endcase
		end
		job_push = accept && (job.raw_cnt != 2'd0 || job.kind != TAIL_NONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= 1'b0;
			pend_q <= 2'd0;
			hcnt_q <= 2'd0;
			acc_q <= '0;
		end else begin
			if (cfg_we) begin
				esc_q <= cfg_data;
			end
			if (accept) begin
				pend_q <= pend_n;
				hcnt_q <= hcnt_n;
				acc_q <= acc_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && held_we) begin
			held_q[held_idx] <= b;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/jse_fifo.sv
`default_nettype none
module jse_fifo
	import jse_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire job_t wr_data,
	output logic      full,
	input  wire logic rd_en,
	output job_t      rd_data,
	output logic      not_empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != CW'(0));
	assign do_wr     = wr_en && !full;
	assign do_rd     = rd_en && not_empty;
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/jse_back.sv
`default_nettype none
module jse_back
	import jse_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic job_valid,
	input  wire job_t job,
	output logic      job_pop,
	input  wire logic pop,
	output logic      empty,
	output out_word_t result
);

	logic             vld_q;
	logic [STEP_W-1:0] step_q;
	out_word_t        out_q;

	logic [STEP_W-1:0] total;
	logic [STEP_W-1:0] t;
	logic [STEP_W-1:0] p;
	logic [15:0]       u;
	logic [7:0]        esc_ch;
	logic [7:0]        ch;
	logic              last;
	logic              pop_ok;
	logic              advance;

	assign total = {2'b00, job.raw_cnt} + tail_len(job.kind);
	assign t = step_q - {2'b00, job.raw_cnt};
	assign last = (step_q == total - STEP_W'(1));
	assign pop_ok = pop && vld_q;
	assign advance = job_valid && (!vld_q || pop_ok);
	assign job_pop = advance && last;

	// Each \uxxxx escape is six characters; the second of a pair uses the low half.
	always_comb begin
		if (t < STEP_W'(6)) begin
			u = job.hi;
			p = t;
		end else begin
			u = job.lo;
			p = t - STEP_W'(6);
		end
		case (p)
			STEP_W'(0): esc_ch = CH_BSLASH;
			STEP_W'(1): esc_ch = CH_U;
			STEP_W'(2): esc_ch = hex_char(u[15:12]);
			STEP_W'(3): esc_ch = hex_char(u[11:8]);
			STEP_W'(4): esc_ch = hex_char(u[7:4]);
			default:    esc_ch = hex_char(u[3:0]);
		endcase
	end

	always_comb begin
		if (step_q < {2'b00, job.raw_cnt}) begin
			case (step_q[1:0])
				2'd0:    ch = job.raw_bytes[0];
				2'd1:    ch = job.raw_bytes[1];
				default: ch = job.raw_bytes[2];
			endcase
		end else begin
			case (job.kind)
				TAIL_CHAR:  ch = job.chr;
				TAIL_SHORT: ch = (t == STEP_W'(0)) ? CH_BSLASH : job.chr;
				TAIL_U1:    ch = esc_ch;
				TAIL_U2:    ch = esc_ch;
				default:    ch = 8'h00;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (advance) begin
				vld_q <= 1'b1;
				step_q <= last ? '0 : step_q + STEP_W'(1);
			end else if (pop_ok) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.out_char <= ch;
			out_q.run_last <= last;
		end
	end

	assign empty  = !vld_q;
	assign result = out_q;

endmodule
`default_nettype wire

// File: hw/rtl/json_string_escaper_top.sv
// JSON string escaper.
// Input queue port: drive item and raise push; a word is taken at a clock edge
// with push high and full low. Each word is one string byte plus a flag for the
// string's last byte. Result queue port: while empty is low, result holds the
// oldest escaped character; raising pop takes it. run_last marks the final
// character of one input byte. If escaping, a mid-string lead byte adds none.
// cfg_we/cfg_data write the unicode escape enable; change it only while idle.
// The first character of a byte's run shows on result after the job queue and
// the back end's output register, when the back end is free.
// Throughput: one character per cycle out of the back end's step counter while
// pop keeps up; a plain byte gives one character, a short escape two, \uxxxx six
// and a surrogate pair twelve. A broken sequence adds a character for each held
// byte it flushes. The front end takes a byte per cycle until the job queue
// between the two halves fills (QUEUE_DEPTH entries), then full goes high. If pop
// stays low the result holds, the back end stops, the queue fills and full pushes
// back on the writer.
// Reset clears the decoder state, the queue and the output; the unicode escape
// enable comes up 0.
`default_nettype none
module json_string_escaper_top
	import jse_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire in_word_t item,
	output logic          empty,
	input  wire logic     pop,
	output out_word_t     result,
	input  wire logic     cfg_we,
	input  wire logic     cfg_data
);

	logic accept;
	logic job_push;
	job_t job_in;
	job_t job_head;
	logic job_valid;
	logic job_pop;

	assign accept = push && !full;

	jse_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.item     (item),
		.accept   (accept),
		.job_push (job_push),
		.job      (job_in)
	);

	jse_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (job_push),
		.wr_data   (job_in),
		.full      (full),
		.rd_en     (job_pop),
		.rd_data   (job_head),
		.not_empty (job_valid)
	);

	jse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job       (job_head),
		.job_pop   (job_pop),
		.pop       (pop),
		.empty     (empty),
		.result    (result)
	);

endmodule
`default_nettype wire

// File: hw/rtl/jse_checker.sv
`default_nettype none
module jse_checker
	import jse_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      push,
	input wire logic      full,
	input wire logic      empty,
	input wire logic      pop,
	input wire out_word_t result
);

	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result port not empty during reset");

	a_reset_not_full: assert property (@(posedge clk) !arst_n |-> !full)
		else $error("input port full during reset");

	// The rest of a run is produced back to back, so taking a non-final
	// character always leaves the next one waiting.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !result.run_last) |=> !empty)
		else $error("gap inside an escape run");

	a_full_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without a push");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result word changed");

endmodule

bind json_string_escaper_top jse_checker u_jse_checker (.*);
`default_nettype wire
